// File: hdl/sfp_pkg.sv
// Shared types and constants for the serial frame parser with XOR check.
// No dependencies; every other file in hdl depends on this package.
package sfp_pkg;

  localparam int MaxFrameBytes = 30;
  localparam int CntW          = $clog2(MaxFrameBytes + 1);
  localparam int AddrW         = $clog2(MaxFrameBytes);
  localparam int IdxW          = 5;

  typedef logic [7:0] byte_t;

  localparam byte_t SyncCode  = 8'hB1;
  localparam byte_t AckCode   = 8'h06;
  localparam byte_t NackCode  = 8'h15;
  localparam byte_t CheckSeed = 8'hFF;

  typedef enum logic [2:0] {
    ST_NONE = 3'd0,
    ST_ACK  = 3'd1,
    ST_NACK = 3'd2,
    ST_BYTE = 3'd3,
    ST_ERR  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE = 2'd0,
    SQ_READ = 2'd1,
    SQ_LOAD = 2'd2
  } seq_t;

endpackage

// File: hdl/sfp_if.sv
// Valid/ready channel interfaces for the serial frame parser.
// Depends on sfp_pkg for payload types.
interface sfp_in_if;
  logic           valid;
  logic           ready;
  sfp_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_out_if;
  logic           valid;
  logic           ready;
  logic [2:0]     status;
  sfp_pkg::byte_t frame_byte;
  logic [sfp_pkg::IdxW-1:0] byte_index;
  logic           is_last;

  modport source (output valid, output status, output frame_byte, output byte_index,
                  output is_last, input ready);
  modport sink   (input valid, input status, input frame_byte, input byte_index,
                  input is_last, output ready);
endinterface

// File: hdl/serial_frame_parser_xor.sv
// Serial frame parser: hunts for a start byte, stores the frame, checks the XOR.
// Depends on sfp_pkg and the channel interfaces in sfp_if.sv.
//
// Usage:
//   in_ch carries received bytes (rx_byte), one item per valid/ready handshake.
//   out_ch carries results: status, frame_byte, byte_index and is_last.
//   Every accepted byte yields one result, loaded into the output register at
//   the clock edge that accepts it, except a check byte that matches: it
//   yields one status-3 result per stored frame byte, the last one marked.
//   A matching frame is read out of the frame store byte by byte: a registered
//   memory read (SQ_READ), then a load of the output register (SQ_LOAD), which
//   waits while the output register holds a result not yet taken.
//   in_ch.ready is low during that readout and whenever the output register
//   holds a result that the receiver has not taken; a stalled receiver holds
//   the result in place and stops the block.
//   Reset (rst_n low, synchronous) returns to hunting and empties the output
//   register. The frame store needs no clearing: an entry is read only after
//   it was written in the current frame.
module serial_frame_parser_xor (
  input  logic       clk,
  input  logic       rst_n,
  sfp_in_if.sink     in_ch,
  sfp_out_if.source  out_ch
);
  import sfp_pkg::*;

  phase_t            phase_r, phase_nxt;
  seq_t              seq_r, seq_nxt;
  byte_t             check_r, check_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  byte_t             len_r, len_nxt;
  logic [AddrW-1:0]  rd_idx_r, rd_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  byte_t             fbyte_r, fbyte_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic              last_r, last_nxt;

  byte_t             store_mem [MaxFrameBytes];
  byte_t             mem_q_r;
  logic              mem_we;

  logic              out_free;
  logic              in_ready;
  logic              accept;
  logic              rd_last;
  byte_t             length;
  byte_t             rx;

  assign rx       = in_ch.rx_byte;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (seq_r == SQ_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ready;
  assign rd_last  = (CntW'(rd_idx_r) + CntW'(1)) == cnt_r;
  assign length   = (cnt_r == '0) ? rx : len_r;

  always_comb begin
    phase_nxt     = phase_r;
    seq_nxt       = seq_r;
    check_nxt     = check_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    fbyte_nxt     = fbyte_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    mem_we        = 1'b0;

    if (accept) begin
      // single result by default; the frame readout below overrides it
      out_valid_nxt = 1'b1;
      status_nxt    = ST_NONE;
      fbyte_nxt     = '0;
      idx_nxt       = '0;
      last_nxt      = 1'b1;
      case (phase_r)
        PH_HUNT: begin
          if (rx == SyncCode) begin
            check_nxt = CheckSeed;
            cnt_nxt   = '0;
            phase_nxt = PH_DATA;
          end else if (rx == AckCode) begin
            status_nxt = ST_ACK;
          end else if (rx == NackCode) begin
            status_nxt = ST_NACK;
          end else begin
            status_nxt = ST_ERR;
          end
        end
        PH_DATA: begin
          if (cnt_r < CntW'(MaxFrameBytes)) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CntW'(1);
            if (cnt_r == '0) begin
              len_nxt = rx;
            end else begin
              check_nxt = check_r ^ rx;
            end
            if (8'(cnt_nxt) == length) begin
              phase_nxt = PH_CHECK;
            end
          end else begin
            // overlong frame: drop the byte
            phase_nxt  = PH_HUNT;
            status_nxt = ST_ERR;
          end
        end
        PH_CHECK: begin
          phase_nxt = PH_HUNT;
          if (rx != check_r || cnt_r == '0) begin
            status_nxt = ST_ERR;
          end else begin
            out_valid_nxt = 1'b0;
            seq_nxt       = SQ_READ;
            rd_idx_nxt    = '0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end

    case (seq_r)
      SQ_READ: begin
        seq_nxt = SQ_LOAD;
      end
      SQ_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_BYTE;
          fbyte_nxt     = mem_q_r;
          idx_nxt       = IdxW'(rd_idx_r);
          last_nxt      = rd_last;
          if (rd_last) begin
            seq_nxt = SQ_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + AddrW'(1);
            seq_nxt    = SQ_READ;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      seq_r       <= SQ_IDLE;
      check_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seq_r       <= seq_nxt;
      check_r     <= check_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    rd_idx_r <= rd_idx_nxt;
    status_r <= status_nxt;
    fbyte_r  <= fbyte_nxt;
    idx_r    <= idx_nxt;
    last_r   <= last_nxt;
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[cnt_r[AddrW-1:0]] <= rx;
    end
    mem_q_r <= store_mem[rd_idx_r];
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.frame_byte = fbyte_r;
  assign out_ch.byte_index = idx_r;
  assign out_ch.is_last    = last_r;

  a_no_input_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != SQ_IDLE) |-> !in_ready)
    else $error("input accepted during frame readout");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxFrameBytes))
    else $error("byte count beyond frame store depth");

  a_rd_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != SQ_IDLE) |-> (CntW'(rd_idx_r) < cnt_r))
    else $error("readout index past stored frame");

  a_load_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_LOAD && out_free) |=> (out_valid_r && status_r == ST_BYTE))
    else $error("frame byte not loaded into output register");

  a_last_ends_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_LOAD && out_free && rd_last) |=> (seq_r == SQ_IDLE && last_r))
    else $error("readout did not end on last frame byte");

endmodule
